// ----- hw/rtl/window_average_charge_switch_macros.svh -----
// Assertion macros used by the charge switch back end.
// Depends on nothing; included by modules that carry assertions.
`ifndef WINDOW_AVERAGE_CHARGE_SWITCH_MACROS_SVH
`define WINDOW_AVERAGE_CHARGE_SWITCH_MACROS_SVH
// Implication checked on every clock, disabled in reset.
`define WACS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked on every clock, disabled in reset.
`define WACS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- hw/rtl/wacs_pkg.sv -----
// Shared types and constants of the window average charge switch.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package wacs_pkg;
   localparam int WINDOW = 12;
   localparam int NCUR = 6;
   localparam int SLOT_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SUM_W = 15 + $clog2(WINDOW);
   localparam int CH_W = $clog2(NCUR + 1);
   localparam logic [16:0] BATT_MAX = 17'd16383;
   // floor(x / 1000) is floor(((x >> 3) * BATT_RECIP) >> BATT_SHIFT) for any 26-bit x.
   localparam logic [23:0] BATT_RECIP = 24'd8589935;
   localparam int BATT_SHIFT = 30;
   // floor(s / WINDOW) is floor((s * AVG_RECIP) >> AVG_SHIFT) for any SUM_W-bit s.
   localparam int AVG_SHIFT = SUM_W + $clog2(WINDOW);
   localparam int PROD_W = 2 * SUM_W + 1;
   localparam logic [SUM_W:0] AVG_RECIP =
      (SUM_W + 1)'(((64'd1 << AVG_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
   localparam logic [2:0] REG_REF = 3'd0;
   localparam logic [2:0] REG_DIV = 3'd1;
   localparam logic [2:0] REG_STOP = 3'd2;
   localparam logic [2:0] REG_SAVE = 3'd3;
   localparam logic [2:0] REG_NORM = 3'd4;
   localparam logic [2:0] REG_FROM = 3'd5;
   localparam logic [2:0] REG_UNTIL = 3'd6;

   typedef struct packed {
      logic [4:0] hour;
      logic [6:0][9:0] code;
   } item_type;

   typedef struct packed {
      logic [12:0] ref_mv;
      logic [12:0] div_milli;
      logic [13:0] stop_mv;
      logic [13:0] save_mv;
      logic [13:0] norm_mv;
      logic [4:0] from_hr;
      logic [4:0] until_hr;
   } cfg_type;

   function automatic logic [11:0] cur_offset(input logic [CH_W-1:0] i);
      case (i)
         3'd1: cur_offset = 12'd2481;
         3'd4: cur_offset = 12'd2471;
         3'd5: cur_offset = 12'd2472;
         default: cur_offset = 12'd2475;
      endcase
   endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/wacs_front.sv -----
// Front end: accepts sample words and holds them in a two-entry queue.
// Depends on wacs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wacs_front import wacs_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   output logic full,
   input wire item_type push_item,
   output logic q_valid,
   input wire logic q_take,
   output item_type q_item
);
   item_type mem [2];
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full = cnt_ff == 2'd2;
   assign q_valid = cnt_ff != 2'd0;
   assign q_item = mem[rd_ff];
   assign do_push = push && !full;
   assign do_pop = q_take && q_valid;

   always_comb begin
      rd_in = rd_ff ^ do_pop;
      wr_in = wr_ff ^ do_push;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_item;
      end
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/wacs_back.sv -----
// Back end: converts one word, updates the rings and running sums, runs the check.
// Depends on wacs_pkg and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "window_average_charge_switch_macros.svh"
module wacs_back import wacs_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire cfg_type cfg,
   input wire logic q_valid,
   output logic q_take,
   input wire item_type q_item,
   output logic res_valid,
   input wire logic res_take,
   output logic [13:0] avg_batt,
   output logic [14:0] avg_cur [NCUR],
   output logic charge,
   output logic checked
);
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_MUL = 6'b000010, S_CONV = 6'b000100,
      S_SCALE = 6'b001000, S_SUM = 6'b010000, S_DONE = 6'b100000
   } state_type;

   state_type st_ff, st_in;
   logic [14:0] ring [NCUR+1][WINDOW];
   logic [SUM_W-1:0] sum_ff [NCUR+1];
   logic [CH_W-1:0] ch_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [CNT_W-1:0] since_ff;
   logic [22:0] mv_prod_ff;
   logic [25:0] batt_prod_ff;
   logic [14:0] old_ff, val_ff;
   logic [13:0] av_b_ff;
   logic [14:0] av_c_ff [NCUR];
   logic wrap_ff;
   logic flag_ff;
   item_type it_ff;
   logic [12:0] mv;
   logic [46:0] batt_mul;
   logic [16:0] batt_q;
   logic [14:0] cur_val, store_val, old_val, avg_val;
   logic [SUM_W-1:0] total;
   logic saving;
   logic handoff;

   function automatic logic [14:0] avg_of(input logic [SUM_W-1:0] s);
      logic [PROD_W-1:0] p;
      p = PROD_W'(s) * PROD_W'(AVG_RECIP);
      avg_of = 15'(p >> AVG_SHIFT);
   endfunction

   assign mv = 13'(mv_prod_ff >> 10);
   assign batt_mul = 47'(batt_prod_ff[25:3]) * 47'(BATT_RECIP);
   assign batt_q = 17'(batt_mul >> BATT_SHIFT);
   assign cur_val = (12'(mv) >= cur_offset(ch_ff) || mv[12]) ? 15'd0 :
                    15'(cur_offset(ch_ff) - 12'(mv)) * 15'd10;
   assign store_val = (ch_ff == '0) ? ((batt_q > BATT_MAX) ? 15'(BATT_MAX) : 15'(batt_q))
                                     : cur_val;
   // Slots are filled in order after reset, so before the first wrap the old entry is zero.
   assign old_val = wrap_ff ? old_ff : 15'd0;
   assign total = sum_ff[ch_ff] - SUM_W'(old_val) + SUM_W'(val_ff);
   assign avg_val = avg_of(total);
   assign saving = (cfg.from_hr > cfg.until_hr) ?
      (it_ff.hour >= cfg.from_hr || it_ff.hour <= cfg.until_hr) :
      (it_ff.hour >= cfg.from_hr && it_ff.hour <= cfg.until_hr);
   assign q_take = st_ff == S_IDLE && q_valid;
   assign handoff = st_ff == S_DONE && (!res_valid || res_take);

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: if (q_valid) st_in = S_MUL;
         S_MUL: st_in = S_CONV;
         S_CONV: st_in = S_SCALE;
         S_SCALE: st_in = S_SUM;
         S_SUM: st_in = (ch_ff == CH_W'(NCUR)) ? S_DONE : S_MUL;
         S_DONE: if (handoff) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (st_ff)
         S_IDLE: begin
            it_ff <= q_item;
            ch_ff <= '0;
         end
         S_MUL: mv_prod_ff <= 23'(it_ff.code[CH_W'(NCUR) - ch_ff]) * 23'(cfg.ref_mv);
         S_CONV: begin
            batt_prod_ff <= 26'(mv) * 26'(cfg.div_milli);
            old_ff <= ring[ch_ff][slot_ff];
         end
         S_SCALE: val_ff <= store_val;
         S_SUM: begin
            ring[ch_ff][slot_ff] <= val_ff;
            if (ch_ff == '0) av_b_ff <= 14'(avg_val);
            else av_c_ff[ch_ff - 1'b1] <= avg_val;
            ch_ff <= ch_ff + 1'b1;
         end
         default: ;
      endcase
      if (reset) begin
         st_ff <= S_IDLE;
         res_valid <= 1'b0;
         slot_ff <= '0;
         since_ff <= '0;
         flag_ff <= 1'b0;
         checked <= 1'b0;
         wrap_ff <= 1'b0;
         for (int c = 0; c <= NCUR; c++) sum_ff[c] <= '0;
      end else begin
         st_ff <= st_in;
         if (st_ff == S_SUM) sum_ff[ch_ff] <= total;
         if (handoff) begin
            res_valid <= 1'b1;
            avg_batt <= av_b_ff;
            avg_cur <= av_c_ff;
            slot_ff <= (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
            if (slot_ff == SLOT_W'(WINDOW - 1)) wrap_ff <= 1'b1;
            checked <= since_ff >= CNT_W'(WINDOW);
            if (since_ff >= CNT_W'(WINDOW)) begin
               since_ff <= '0;
               if (flag_ff) begin
                  if (!saving && av_b_ff >= cfg.stop_mv) flag_ff <= 1'b0;
               end else if ((saving && av_b_ff < cfg.save_mv) ||
                            (!saving && av_b_ff < cfg.norm_mv)) begin
                  flag_ff <= 1'b1;
               end
            end else begin
               since_ff <= since_ff + 1'b1;
            end
         end else if (res_take) begin
            res_valid <= 1'b0;
         end
      end
   end

   always_comb begin
      charge = flag_ff;
      if (checked) charge = flag_ff;
   end

   `WACS_ASSERT_IMP(a_take_idle, clock, reset, q_take, st_ff == S_IDLE)
   `WACS_ASSERT_IMP(a_since_rng, clock, reset, 1'b1, since_ff <= CNT_W'(WINDOW))
   `WACS_ASSERT_NXT(a_chk_clear, clock, reset, res_valid && $rose(checked), since_ff == '0)
endmodule
`default_nettype wire

// ----- hw/rtl/window_average_charge_switch.sv -----
// Window average charge switch, top level.
// A word passes through the input queue, then the multiply, convert, scale and sum steps
// for each of seven channels and a handoff, before its result word is on the rsp_ ports.
// A new word is taken only after the last is handed off, which waits for any unpopped result.
// Reset is synchronous and active high; it clears the running sums, counters, flag, fill
// flag and queue and restores the register defaults. Unwritten ring slots count as zero.
`timescale 1ns / 1ps
`default_nettype none
module window_average_charge_switch import wacs_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   output logic full,
   input wire logic [4:0] req_hour_of_day,
   input wire logic [9:0] req_battery_code,
   input wire logic [9:0] req_solar_code,
   input wire logic [9:0] req_desktop_code,
   input wire logic [9:0] req_mains_code,
   input wire logic [9:0] req_radio_one_code,
   input wire logic [9:0] req_radio_two_code,
   input wire logic [9:0] req_network_code,
   output logic empty,
   input wire logic pop,
   output logic [13:0] rsp_avg_battery_mv,
   output logic [14:0] rsp_avg_solar_ma,
   output logic [14:0] rsp_avg_desktop_ma,
   output logic [14:0] rsp_avg_mains_ma,
   output logic [14:0] rsp_avg_radio_one_ma,
   output logic [14:0] rsp_avg_radio_two_ma,
   output logic [14:0] rsp_avg_network_ma,
   output logic rsp_charging_on,
   output logic rsp_check_done,
   input wire logic csr_write,
   input wire logic [2:0] csr_index,
   input wire logic [13:0] csr_data
);
   // The configuration registers, held in one struct for the back end.
   cfg_type cfg_ff;
   item_type push_item, q_item;
   logic q_valid, q_take, res_valid;
   logic [14:0] avg_cur [NCUR];

   // Code array index 6 is the battery, then the currents down to 0.
   always_comb begin
      push_item.hour = req_hour_of_day;
      push_item.code[6] = req_battery_code;
      push_item.code[5] = req_solar_code;
      push_item.code[4] = req_desktop_code;
      push_item.code[3] = req_mains_code;
      push_item.code[2] = req_radio_one_code;
      push_item.code[1] = req_radio_two_code;
      push_item.code[0] = req_network_code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ref_mv <= 13'd5010;
         cfg_ff.div_milli <= 13'd3175;
         cfg_ff.stop_mv <= 14'd13400;
         cfg_ff.save_mv <= 14'd13300;
         cfg_ff.norm_mv <= 14'd12900;
         cfg_ff.from_hr <= 5'd22;
         cfg_ff.until_hr <= 5'd8;
      end else if (csr_write) begin
         case (csr_index)
            REG_REF: cfg_ff.ref_mv <= csr_data[12:0];
            REG_DIV: cfg_ff.div_milli <= csr_data[12:0];
            REG_STOP: cfg_ff.stop_mv <= csr_data;
            REG_SAVE: cfg_ff.save_mv <= csr_data;
            REG_NORM: cfg_ff.norm_mv <= csr_data;
            REG_FROM: cfg_ff.from_hr <= csr_data[4:0];
            REG_UNTIL: cfg_ff.until_hr <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   wacs_front u_front (
      .clock, .reset, .push, .full, .push_item,
      .q_valid, .q_take, .q_item
   );

   // The back end holds its finished word in output registers, so a new word
   // is taken from the queue while the last one waits to be popped.
   wacs_back u_back (
      .clock, .reset, .cfg(cfg_ff), .q_valid, .q_take, .q_item,
      .res_valid, .res_take(pop && res_valid),
      .avg_batt(rsp_avg_battery_mv), .avg_cur,
      .charge(rsp_charging_on), .checked(rsp_check_done)
   );

   assign empty = !res_valid;
   assign rsp_avg_solar_ma = avg_cur[0];
   assign rsp_avg_desktop_ma = avg_cur[1];
   assign rsp_avg_mains_ma = avg_cur[2];
   assign rsp_avg_radio_one_ma = avg_cur[3];
   assign rsp_avg_radio_two_ma = avg_cur[4];
   assign rsp_avg_network_ma = avg_cur[5];
endmodule
`default_nettype wire
